### rtl/agc_frame_energy_estimator_unit_defines.svh
// Assertion macros used by the port-level checker.
`ifndef AGC_FRAME_ENERGY_ESTIMATOR_UNIT_DEFINES_SVH
`define AGC_FRAME_ENERGY_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/afe_pkg.sv
//------------------------------------------------------------------------------
// afe_pkg
// Types and constants of the frame energy estimator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afe_pkg;

    localparam logic [15:0] GAIN_ONE  = 16'd16384;
    localparam logic [15:0] GAIN_MIN  = 16'd1638;
    localparam logic [15:0] GAIN_MAX  = 16'd32768;
    localparam logic [14:0] GAIN_DOWN = 15'd13926;
    localparam logic [14:0] GAIN_UP   = 15'd17203;
    localparam logic [14:0] GAIN_KEEP = 15'd16384;
    localparam logic [16:0] PEAK_HIGH = 17'd400;
    localparam logic [16:0] PEAK_LOW  = 17'd100;
    localparam logic [7:0]  ALPHA     = 8'd122;
    localparam logic [7:0]  BETA      = 8'd51;

    typedef struct packed {
        logic signed [15:0] sample_i;
        logic signed [15:0] sample_q;
        logic [15:0]        frame_length;
    } sample_t;

    typedef struct packed {
        logic [24:0] energy;
        logic [15:0] gain_out;
    } result_t;

    // frame descriptor handed from front to back
    typedef struct packed {
        logic [16:0] peak;
        logic [8:0]  count;
    } desc_t;

    // sample store write request
    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [16:0] mag_i;
        logic [16:0] mag_q;
    } wr_t;

    function automatic logic [15:0] clamp_gain(input logic [17:0] g);
        logic [15:0] r;
        if (g < 18'(GAIN_MIN))
            r = GAIN_MIN;
        else if (g > 18'(GAIN_MAX))
            r = GAIN_MAX;
        else
            r = g[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/afe_front.sv
//------------------------------------------------------------------------------
// afe_front
// Sample intake: magnitudes, frame position, counted length and peak.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_front #(
    parameter int FRAME_SAMPLES = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 accept,
    input  afe_pkg::sample_t    sample,
    output afe_pkg::wr_t        wr,
    output logic                push,
    output afe_pkg::desc_t      desc
);
    import afe_pkg::*;

    localparam int AW = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int CW = $clog2(FRAME_SAMPLES + 1);

    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [16:0]   peak_reg, peak_next;

    logic          first, last;
    logic [CW-1:0] cnt_cur;
    logic [16:0]   ext_i, ext_q, mag_i, mag_q, mag_sum, peak_base;

    always_comb
    begin
        first   = (pos_reg == '0);
        last    = (pos_reg == AW'(FRAME_SAMPLES - 1));
        ext_i   = {sample.sample_i[15], sample.sample_i};
        ext_q   = {sample.sample_q[15], sample.sample_q};
        mag_i   = sample.sample_i[15] ? 17'(-ext_i) : ext_i;
        mag_q   = sample.sample_q[15] ? 17'(-ext_q) : ext_q;
        mag_sum = mag_i + mag_q;
        if (sample.frame_length == 16'd0 || sample.frame_length > 16'(FRAME_SAMPLES))
            cnt_cur = CW'(FRAME_SAMPLES);
        else
            cnt_cur = CW'(sample.frame_length);
        if (!first)
            cnt_cur = cnt_reg;
        peak_base = first ? 17'd0 : peak_reg;
        peak_next = peak_base;
        if (CW'(pos_reg) < cnt_cur && mag_sum > peak_base)
            peak_next = mag_sum;
        cnt_next = cnt_cur;
        pos_next = last ? '0 : pos_reg + 1'b1;

        wr.en    = accept;
        wr.addr  = 8'(pos_reg);
        wr.mag_i = mag_i;
        wr.mag_q = mag_q;
        push       = accept && last;
        desc.peak  = peak_next;
        desc.count = 9'(cnt_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cnt_reg  <= '0;
            peak_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            peak_reg <= last ? 17'd0 : peak_next;
        end
    end

endmodule

`default_nettype wire

### rtl/afe_queue.sv
//------------------------------------------------------------------------------
// afe_queue
// Two-entry queue of frame descriptors between front and back.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  afe_pkg::desc_t  din,
    input  wire             pop,
    output afe_pkg::desc_t  dout,
    output logic            not_empty
);
    import afe_pkg::*;

    desc_t      ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    always_comb
    begin
        not_empty = (cnt_reg != 2'd0);
        do_pop    = pop && not_empty;
        do_push   = push && (cnt_reg != 2'd2);
        dout      = ent_reg[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/afe_back.sv
//------------------------------------------------------------------------------
// afe_back
// Frame processing: gain update, scaled magnitude sum, rounding, division.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_back #(
    parameter int FRAME_SAMPLES = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  afe_pkg::wr_t     wr,
    input  afe_pkg::desc_t   desc,
    input  wire              desc_valid,
    output logic             pop,
    output logic             active,
    input  wire              cfg_valid,
    output logic             cfg_ready,
    input  wire [15:0]       cfg_data,
    output logic             result_valid,
    output afe_pkg::result_t result
);
    import afe_pkg::*;

    localparam int AW    = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int CW    = $clog2(FRAME_SAMPLES + 1);
    localparam int SUM_W = 24 + CW;
    localparam int RND_W = SUM_W - 7;
    localparam int NUM_W = RND_W + 16;
    localparam int BW    = $clog2(NUM_W + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GMUL  = 3'd1;
    localparam logic [2:0] S_GSET  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [33:0] mem [FRAME_SAMPLES];
    logic [33:0] mem_q;

    logic [2:0]       state_reg, state_next;
    logic [15:0]      gain_reg;
    logic [16:0]      peak_reg;
    logic [CW-1:0]    cnt_reg, idx_reg;
    logic [30:0]      prod_reg;
    logic             v1_reg, v2_reg;
    logic [16:0]      sa_reg, sb_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [16:0]      rem_reg;
    logic [BW-1:0]    bit_reg;
    logic             res_v_reg;
    result_t          res_reg;

    logic [14:0]      coef;
    logic [17:0]      gain_rnd;
    logic             issue;
    logic [33:0]      pa, pb;
    logic [16:0]      hi, lo;
    logic [SUM_W-1:0] term;
    logic [RND_W-1:0] rnd;
    logic [16:0]      den;
    logic [17:0]      trial;
    logic             ge;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr[AW-1:0]] <= {wr.mag_i, wr.mag_q};
        mem_q <= mem[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        if (peak_reg > PEAK_HIGH)
            coef = GAIN_DOWN;
        else if (peak_reg < PEAK_LOW)
            coef = GAIN_UP;
        else
            coef = GAIN_KEEP;
        gain_rnd = 18'((32'(prod_reg) + 32'd8192) >> 14);

        issue = (state_reg == S_SCAN) && (idx_reg < cnt_reg);
        pa = 34'(mem_q[33:17]) * 34'(gain_reg) + 34'd8192;
        pb = 34'(mem_q[16:0])  * 34'(gain_reg) + 34'd8192;
        hi = (sa_reg > sb_reg) ? sa_reg : sb_reg;
        lo = (sa_reg > sb_reg) ? sb_reg : sa_reg;
        term = SUM_W'(ALPHA) * SUM_W'(hi) + SUM_W'(BETA) * SUM_W'(lo);
        rnd = RND_W'((acc_reg + SUM_W'(64)) >> 7);

        den   = {gain_reg, 1'b0};
        trial = {rem_reg, num_reg[NUM_W-1]};
        ge    = (trial >= {1'b0, den});

        pop       = (state_reg == S_IDLE) && desc_valid;
        active    = (state_reg != S_IDLE);
        // a queued frame already owns the gain it was accepted under
        cfg_ready = (state_reg == S_IDLE) && !desc_valid;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (desc_valid) state_next = S_GMUL;
            S_GMUL:  state_next = S_GSET;
            S_GSET:  state_next = S_SCAN;
            S_SCAN:  if (!issue && !v1_reg && !v2_reg) state_next = S_ROUND;
            S_ROUND: state_next = S_DIV;
            S_DIV:   if (bit_reg == BW'(NUM_W - 1)) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            peak_reg <= desc.peak;
            cnt_reg  <= CW'(desc.count);
        end
        if (state_reg == S_GMUL)
            prod_reg <= 31'(gain_reg) * 31'(coef);
        sa_reg <= 17'(pa >> 14);
        sb_reg <= 17'(pb >> 14);
        if (state_reg == S_GSET)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + term;
        if (state_reg == S_ROUND)
        begin
            num_reg <= (NUM_W'(rnd) << 15) + NUM_W'(gain_reg);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? 17'(trial - {1'b0, den}) : trial[16:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
        if (state_reg == S_OUT)
        begin
            res_reg.energy   <= quo_reg[24:0];
            res_reg.gain_out <= gain_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gain_reg  <= GAIN_ONE;
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            bit_reg   <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                gain_reg <= clamp_gain(18'(cfg_data));
            else if (state_reg == S_GSET)
                gain_reg <= clamp_gain(gain_rnd);
            if (state_reg == S_GSET)
                idx_reg <= '0;
            else if (issue)
                idx_reg <= idx_reg + 1'b1;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (state_reg == S_ROUND)
                bit_reg <= '0;
            else if (state_reg == S_DIV)
                bit_reg <= bit_reg + 1'b1;
            res_v_reg <= (state_reg == S_OUT);
        end
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

### rtl/agc_frame_energy_estimator_unit.sv
//------------------------------------------------------------------------------
// agc_frame_energy_estimator_unit
// Frame AGC with alpha-max-beta-min energy estimate.
//------------------------------------------------------------------------------
// Usage:
//   Samples enter on sample when start is high and busy low, one per cycle.
//   A frame is FRAME_SAMPLES samples; frame_length is taken from the first.
//   After the last sample of a frame busy rises while the back end takes
//   the frame from the queue, updates the gain, scans the sample store,
//   rounds, runs a bit-serial divider and then loads the result register.
//   result_valid pulses one cycle, right after busy falls, with energy and
//   the new gain; the receiver cannot stall, so nothing is held back.
//   A frame's samples and its processing thus do not overlap; the divider
//   and the single sample store port set how long busy stays high.
//   cfg_data written through cfg_valid/cfg_ready sets the gain (clamped);
//   cfg_ready is high while the back end is idle and no frame waits.
//   Reset: gain is 1.0, the frame position returns to the first sample.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agc_frame_energy_estimator_unit #(
    parameter int FRAME_SAMPLES = 32
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  afe_pkg::sample_t  sample,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire [15:0]        cfg_data,
    output logic              result_valid,
    output afe_pkg::result_t  result
);
    import afe_pkg::*;

    wr_t   wr;
    desc_t push_desc, head_desc;
    logic  push, pop, q_valid, back_active, accept;

    assign busy   = q_valid || back_active;
    assign accept = start && !busy;

    afe_front #(.FRAME_SAMPLES(FRAME_SAMPLES)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .wr     (wr),
        .push   (push),
        .desc   (push_desc)
    );

    afe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (push_desc),
        .pop       (pop),
        .dout      (head_desc),
        .not_empty (q_valid)
    );

    afe_back #(.FRAME_SAMPLES(FRAME_SAMPLES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .desc         (head_desc),
        .desc_valid   (q_valid),
        .pop          (pop),
        .active       (back_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

### rtl/afe_checker.sv
//------------------------------------------------------------------------------
// afe_checker
// Port-level checks of the frame energy estimator, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "agc_frame_energy_estimator_unit_defines.svh"

module afe_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              start,
    input wire              busy,
    input wire              result_valid,
    input afe_pkg::result_t result
);
    import afe_pkg::*;

    `AFE_ASSERT_NEXT(a_single_pulse, result_valid, !result_valid, "result strobe repeated")
    `AFE_ASSERT_NOW(a_gain_range, result_valid, (result.gain_out >= GAIN_MIN) && (result.gain_out <= GAIN_MAX), "gain out of range")
    // the result register loads on the last busy cycle
    `AFE_ASSERT_NOW(a_idle_at_result, result_valid, !busy, "busy while result shown")
    `AFE_ASSERT_NEXT(a_no_result_from_idle, !busy && !start, !result_valid, "result without work")

endmodule

bind agc_frame_energy_estimator_unit afe_checker u_afe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

### test/afe_frame_checker.sv
//------------------------------------------------------------------------------
// afe_frame_checker
// Watches sample requests, gain writes and results of the frame energy
// estimator, predicts each frame's energy and gain, and counts mismatches.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module afe_frame_checker #(
    parameter int FRAME_SAMPLES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  afe_pkg::sample_t sample,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [15:0]      cfg_data,
    input  logic             result_valid,
    input  afe_pkg::result_t result,
    output int               fail_count,
    output int               pending
);
    import afe_pkg::*;

    logic [16:0]   mag_i_q [FRAME_SAMPLES];
    logic [16:0]   mag_q_q [FRAME_SAMPLES];
    logic [17:0]   cur_gain;
    int            frame_pos;
    int            frame_count;
    logic [17:0]   peak_acc;
    result_t       expected_results[$];

    function automatic logic [16:0] magnitude(input logic signed [15:0] v);
        logic [16:0] m;
        m = v[15] ? 17'(-{v[15], v}) : 17'(v);
        return m;
    endfunction

    function automatic logic [17:0] gain_limit(input logic [63:0] g);
        logic [17:0] r;
        if (g < 64'(GAIN_MIN))
            r = 18'(GAIN_MIN);
        else if (g > 64'(GAIN_MAX))
            r = 18'(GAIN_MAX);
        else
            r = 18'(g);
        return r;
    endfunction

    task automatic accept_sample(input sample_t s);
        logic [16:0] mi;
        logic [16:0] mq;
        logic [63:0] acc;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] rounded;
        result_t     r;
        if (frame_pos == 0)
        begin
            frame_count = (s.frame_length == 0 || s.frame_length > FRAME_SAMPLES)
                          ? FRAME_SAMPLES : int'(s.frame_length);
            peak_acc = 0;
        end
        mi = magnitude(s.sample_i);
        mq = magnitude(s.sample_q);
        mag_i_q[frame_pos] = mi;
        mag_q_q[frame_pos] = mq;
        if (frame_pos < frame_count && 18'(mi) + 18'(mq) > peak_acc)
            peak_acc = 18'(mi) + 18'(mq);
        if (frame_pos + 1 < FRAME_SAMPLES)
        begin
            frame_pos++;
            return;
        end
        if (peak_acc > 18'(PEAK_HIGH))
            cur_gain = gain_limit((64'(cur_gain) * GAIN_DOWN + 8192) >> 14);
        else if (peak_acc < 18'(PEAK_LOW))
            cur_gain = gain_limit((64'(cur_gain) * GAIN_UP + 8192) >> 14);
        acc = 0;
        for (int k = 0; k < frame_count; k++)
        begin
            a = (64'(mag_i_q[k]) * cur_gain + 8192) >> 14;
            b = (64'(mag_q_q[k]) * cur_gain + 8192) >> 14;
            acc += (a > b) ? (ALPHA * a + BETA * b) : (ALPHA * b + BETA * a);
        end
        rounded = (acc + 64) >> 7;
        r.energy = 25'((2 * rounded * GAIN_ONE + cur_gain) / (2 * 64'(cur_gain)));
        r.gain_out = cur_gain[15:0];
        expected_results.insert(expected_results.size(), r);
        frame_pos = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_gain = 18'(GAIN_ONE);
            frame_pos = 0;
            frame_count = FRAME_SAMPLES;
            peak_acc = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result energy=%0d gain=%0d", $time,
                             result.energy, result.gain_out);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (e.energy !== result.energy)
                    begin
                        $display("%0t: energy expected %0d actual %0d", $time,
                                 e.energy, result.energy);
                        fail_count++;
                    end
                    if (e.gain_out !== result.gain_out)
                    begin
                        $display("%0t: gain expected %0d actual %0d", $time,
                                 e.gain_out, result.gain_out);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cur_gain = gain_limit(64'(cfg_data));
            if (start && !busy)
                accept_sample(sample);
        end
        pending = expected_results.size();
    end

endmodule

### test/tb_agc_frame_energy_estimator_unit.sv
//------------------------------------------------------------------------------
// tb_agc_frame_energy_estimator_unit
// Drives frames of I/Q samples and gain writes into the estimator; the
// checker predicts each frame result and the top reports the verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_agc_frame_energy_estimator_unit;
    import afe_pkg::*;

    localparam int FRAME_SAMPLES = 32;
    localparam int DRAIN_CYCLES  = 120;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    sample_t sample = '0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [15:0] cfg_data = '0;
    logic    result_valid;
    result_t result;
    int      fail_count;
    int      pending;
    int      gap_pct;
    int      sent;

    always #6 clk = ~clk;

    agc_frame_energy_estimator_unit #(.FRAME_SAMPLES(FRAME_SAMPLES)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result)
    );

    afe_frame_checker #(.FRAME_SAMPLES(FRAME_SAMPLES)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    // one request, held until accepted; random gap before it
    // start stays high after acceptance unless a gap or a drain follows
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(input logic [15:0] g);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_value(input int level);
        logic signed [15:0] v;
        case ($urandom_range(9))
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            2, 3: v = 16'(signed'($urandom_range(level * 2)) - level);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // frame with random length and an amplitude band that steers the gain
    task automatic send_frame(input int level);
        sample_t s;
        for (int k = 0; k < FRAME_SAMPLES; k++)
        begin
            s.sample_i = ($urandom_range(3) == 0) ? pick_value(level)
                         : 16'(signed'($urandom_range(level * 2)) - level);
            s.sample_q = 16'(signed'($urandom_range(level * 2)) - level);
            case ($urandom_range(5))
                0: s.frame_length = 16'($urandom);
                1: s.frame_length = 16'd0;
                default: s.frame_length = 16'($urandom_range(FRAME_SAMPLES + 1));
            endcase
            send_sample(s);
        end
    endtask

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sample_t s;
        int      lv;
        sent = 0;
        gap_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes: full-scale negative, full-scale positive, zero in a one-sample frame
        s = '{sample_i: 16'sh8000, sample_q: 16'sh8000, frame_length: 16'd0};
        for (int k = 0; k < FRAME_SAMPLES; k++)
            send_sample(s);
        s = '{sample_i: 16'sh7fff, sample_q: 16'sh0001, frame_length: 16'hffff};
        for (int k = 0; k < FRAME_SAMPLES; k++)
            send_sample(s);
        s = '{sample_i: 16'sd0, sample_q: 16'sd0, frame_length: 16'd1};
        for (int k = 0; k < FRAME_SAMPLES; k++)
            send_sample(s);
        // peak inside the hold band
        s = '{sample_i: 16'sd150, sample_q: -16'sd100, frame_length: 16'd33};
        for (int k = 0; k < FRAME_SAMPLES; k++)
            send_sample(s);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_gain(16'd0);
                1: write_gain(16'hffff);
                2: write_gain(GAIN_MIN);
                3: write_gain(GAIN_MAX);
                default: write_gain(16'($urandom));
            endcase
            gap_pct = (phase < 2) ? 18 : (phase < 4) ? 52 : 0;
            for (int f = 0; f < 10; f++)
            begin
                case ($urandom_range(3))
                    0: lv = 40;
                    1: lv = 250;
                    2: lv = 4000;
                    default: lv = 32767;
                endcase
                send_frame(lv);
                if (f == 5)
                    wait_drained();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
